@@ hdl/spq_pkg.sv @@
// Shared types, codes and defaults for the stable priority queue.
package spq_pkg;

  // Default number of entry cells in the chain
  localparam int unsigned CAPACITY = 16;

  // Request codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // One stored entry: rank above payload
  typedef struct packed {
    logic [15:0]        prio;
    logic signed [31:0] data;
  } entry_t;

  // Input beat
  typedef struct packed {
    logic               op;
    logic signed [31:0] data_value;
    logic [15:0]        priority_req;
  } spq_in_t;

  // Output beat
  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_data;
    logic               removed_valid;
    logic [4:0]         entry_count;
  } spq_out_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t entry;
  } spq_ctl_t;

endpackage

@@ hdl/spq_cell.sv @@
// One cell of the sorted chain: holds an entry and shifts left or right.
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::spq_ctl_t ctl_i,
  input  logic            occ_i,
  input  logic            left_behind_i,
  input  spq_pkg::entry_t left_entry_i,
  input  spq_pkg::entry_t right_entry_i,
  output spq_pkg::entry_t entry_o,
  output logic            behind_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // The new entry goes behind this one if it is held and ranks equal or better
  assign behind_o = occ_i && (entry_q.prio <= ctl_i.entry.prio);

  // Keep, take the new entry, or shift in from a neighbour
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (!behind_o) begin
        if (left_behind_i) begin
          entry_d = ctl_i.entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
    end else if (ctl_i.del) begin
      entry_d = right_entry_i;
    end
  end

  // Hold the entry; payload needs no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hdl/stable_priority_queue.sv @@
// Top level of the stable priority queue: cell chain, count and result register.
//
// Bounded priority queue built as a chain of CAPACITY cells, front at cell 0.
// Every cell compares its rank with the request in the same cycle, so one
// insert or delete is taken per clock unless the output stalls, and its result
// appears in the output register on the next cycle. A new beat is accepted
// whenever the output register is empty or being taken in that cycle. Lower
// rank leaves first and equal ranks leave in arrival order. An insert into a
// full queue reports overflow, a delete from an empty queue reports underflow,
// and neither changes the contents. No clearing pass is needed after reset:
// only cells below the entry count are ever read.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  spq_out_t         out_q, out_d;

  logic             accept;
  logic             full, empty;
  spq_ctl_t         ctl;

  entry_t           entries [CAPACITY];
  logic             behind  [CAPACITY];
  logic             occ     [CAPACITY];

  // Accept when the result slot is free or drains this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Broadcast the command to every cell
  always_comb begin
    ctl.ins         = accept && (in_data_i.op == OP_INSERT) && !full;
    ctl.del         = accept && (in_data_i.op == OP_DELETE) && !empty;
    ctl.entry.prio  = in_data_i.priority_req;
    ctl.entry.data  = in_data_i.data_value;
  end

  // Build the chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_b;

    assign occ[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_b = behind[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (occ[i]),
      .left_behind_i (left_b),
      .left_entry_i  (left_e),
      .right_entry_i (right_e),
      .entry_o       (entries[i]),
      .behind_o      (behind[i])
    );
  end

  // Advance the count and form the result beat
  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.del) begin
      count_d = count_q - CNT_W'(1);
    end

    out_d.removed_data  = '0;
    out_d.removed_valid = 1'b0;
    out_d.status        = ST_DONE;
    if (in_data_i.op == OP_INSERT) begin
      if (full) begin
        out_d.status = ST_OVER;
      end
    end else if (empty) begin
      out_d.status = ST_UNDER;
    end else begin
      out_d.removed_data  = entries[0].data;
      out_d.removed_valid = 1'b1;
    end
    out_d.entry_count = 5'(count_d);
  end

  // Hold count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Count never passes the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Delete from empty reports underflow and leaves the count alone
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.op == OP_DELETE && empty) |=>
      (out_q.status == ST_UNDER && count_q == '0 && !out_q.removed_valid))
    else $error("underflow not reported");

  // Insert into full reports overflow and keeps the count
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.op == OP_INSERT && full) |=>
      (out_q.status == ST_OVER && count_q == CNT_W'(CAPACITY)))
    else $error("overflow not reported");

  // A good delete returns a beat and drops the count by one
  a_delete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.del |=> (out_valid_q && out_q.removed_valid &&
                 count_q == $past(count_q) - CNT_W'(1)))
    else $error("delete result mismatch");

  // Front two entries stay in rank order
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (entries[0].prio <= entries[1].prio))
    else $error("chain out of order");

endmodule
